// File: rtl/sddw_pkg.sv
// sddw_pkg: types, constants and helpers for the signed decimal display writer
// no dependencies; used by the interfaces and every rtl module

package sddw_pkg;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned NIB_W       = 4;
	localparam int unsigned MAX_DIGITS  = 8;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// code-b values
	localparam logic [NIB_W-1:0] CODE_BLANK = 4'hF;
	localparam logic [NIB_W-1:0] CODE_MINUS = 4'hA;
	localparam logic [NIB_W-1:0] FIRST_ADDR = 4'h1;
	localparam logic [NIB_W-1:0] COUNT_RESET = 4'd8;

	// reciprocal of ten, exact for every 32-bit magnitude with a shift of 35
	localparam logic [VALUE_W-1:0] RECIP10      = 32'hCCCC_CCCD;
	localparam int unsigned        RECIP10_SHIFT = 35;

	// one queued number, already split into sign and magnitude
	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} queue_entry_t;

	// clamp the digit count register to the usable range
	function automatic logic [NIB_W-1:0] eff_count(input logic [NIB_W-1:0] raw);
		logic [NIB_W-1:0] n;
		n = raw;
		if (n > NIB_W'(MAX_DIGITS))
			n = NIB_W'(MAX_DIGITS);
		if (n == '0)
			n = FIRST_ADDR;
		return n;
	endfunction

endpackage

// File: rtl/sddw_if.sv
// sddw_in_if and sddw_out_if: valid/ready channels of the display writer
// depends on sddw_pkg for field widths

interface sddw_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [sddw_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface sddw_out_if;
	logic                           valid;
	logic                           ready;
	logic [sddw_pkg::NIB_W-1:0]     digit_address;
	logic [sddw_pkg::NIB_W-1:0]     digit_code;
	logic                           last;
	logic                           overflow;

	modport source (output valid, output digit_address, output digit_code,
		output last, output overflow, input ready);
	modport sink (input valid, input digit_address, input digit_code,
		input last, input overflow, output ready);
endinterface

// File: rtl/sddw_front.sv
// sddw_front: accepts numbers, splits sign and magnitude, holds them in a short queue
// depends on sddw_pkg and sddw_in_if

module sddw_front (
	input  logic                  clk,
	input  logic                  arst_n,
	sddw_in_if.sink               in_ch,
	output logic                  q_valid,
	output sddw_pkg::queue_entry_t q_entry,
	input  logic                  q_pop
);

	sddw_pkg::queue_entry_t              entry_q [sddw_pkg::QUEUE_DEPTH];
	logic [sddw_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [sddw_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [sddw_pkg::QCNT_W-1:0]         count_q;
	logic                                push;
	logic                                pop;
	sddw_pkg::queue_entry_t              classified;

	// classify: sign bit and two's complement magnitude
	always_comb begin
		classified.neg = in_ch.value[sddw_pkg::VALUE_W-1];
		classified.mag = classified.neg ? (sddw_pkg::VALUE_W'(0) - in_ch.value) : in_ch.value;
	end

	assign in_ch.ready = (count_q != sddw_pkg::QCNT_W'(sddw_pkg::QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (count_q != '0);
	assign pop         = q_pop && q_valid;
	assign q_entry     = entry_q[rd_ptr_q];

	// queue storage, payload only
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= classified;
	end

	// pointer wrap
	function automatic logic [sddw_pkg::QPTR_W-1:0] next_ptr(input logic [sddw_pkg::QPTR_W-1:0] p);
		if (p == sddw_pkg::QPTR_W'(sddw_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sddw_pkg::QCNT_W'(sddw_pkg::QUEUE_DEPTH))
		else $error("queue fill level beyond depth");
	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill level lost a transfer");
`endif

endmodule

// File: rtl/sddw_back.sv
// sddw_back: sequencer that turns one queued number into digit register writes
// depends on sddw_pkg and sddw_out_if

module sddw_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sddw_pkg::NIB_W-1:0]   count,
	input  logic                         q_valid,
	input  sddw_pkg::queue_entry_t       q_entry,
	output logic                         q_pop,
	sddw_out_if.source                   out_ch
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BLANK = 2'd1;
	localparam logic [1:0] ST_DIGIT = 2'd2;
	localparam logic [1:0] ST_SIGN  = 2'd3;

	logic [1:0]                     state_q;
	logic [sddw_pkg::VALUE_W-1:0]   mag_q;
	logic                           neg_q;
	logic [sddw_pkg::NIB_W-1:0]     cnt_q;
	logic [sddw_pkg::NIB_W-1:0]     addr_q;

	logic                           out_valid_q;
	logic [sddw_pkg::NIB_W-1:0]     out_addr_q;
	logic [sddw_pkg::NIB_W-1:0]     out_code_q;
	logic                           out_last_q;
	logic                           out_ovf_q;

	logic                           adv;
	logic [2*sddw_pkg::VALUE_W-1:0] prod;
	logic [sddw_pkg::VALUE_W-1:0]   quot;
	logic [sddw_pkg::VALUE_W-1:0]   rem_full;
	logic [sddw_pkg::NIB_W-1:0]     digit;
	logic                           more;
	logic                           room;

	// divide by ten through the reciprocal, remainder by shift and add
	always_comb begin
		prod     = (2*sddw_pkg::VALUE_W)'(mag_q) * (2*sddw_pkg::VALUE_W)'(sddw_pkg::RECIP10);
		quot     = sddw_pkg::VALUE_W'(prod >> sddw_pkg::RECIP10_SHIFT);
		rem_full = mag_q - ((quot << 3) + (quot << 1));
		digit    = rem_full[sddw_pkg::NIB_W-1:0];
		more     = (quot != '0) || neg_q;
		room     = (addr_q < cnt_q);
	end

	// step when busy and the output register is free or being drained
	assign adv   = (state_q != ST_IDLE) && (!out_valid_q || out_ch.ready);
	assign q_pop = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid)
						state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					if (adv && addr_q == sddw_pkg::FIRST_ADDR)
						state_q <= ST_DIGIT;
				end
				ST_DIGIT: begin
					if (adv) begin
						if (more && room)
							state_q <= (quot != '0) ? ST_DIGIT : ST_SIGN;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_SIGN: begin
					if (adv)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers of the current number
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (q_valid) begin
				mag_q  <= q_entry.mag;
				neg_q  <= q_entry.neg;
				cnt_q  <= count;
				addr_q <= count;
			end
		end else if (adv) begin
			if (state_q == ST_BLANK) begin
				if (addr_q == sddw_pkg::FIRST_ADDR)
					addr_q <= sddw_pkg::FIRST_ADDR;
				else
					addr_q <= addr_q - 1'b1;
			end else if (state_q == ST_DIGIT) begin
				mag_q  <= quot;
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_addr_q <= addr_q;
			unique case (state_q)
				ST_BLANK: begin
					out_code_q <= sddw_pkg::CODE_BLANK;
					out_last_q <= 1'b0;
					out_ovf_q  <= 1'b0;
				end
				ST_DIGIT: begin
					out_code_q <= digit;
					out_last_q <= !(more && room);
					out_ovf_q  <= more && !room;
				end
				default: begin
					out_code_q <= sddw_pkg::CODE_MINUS;
					out_last_q <= 1'b1;
					out_ovf_q  <= 1'b0;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.digit_address = out_addr_q;
	assign out_ch.digit_code    = out_code_q;
	assign out_ch.last          = out_last_q;
	assign out_ch.overflow      = out_ovf_q;

`ifndef SYNTHESIS
	a_sign_needs_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |-> neg_q)
		else $error("sign step for a positive number");
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (addr_q >= sddw_pkg::FIRST_ADDR && addr_q <= cnt_q))
		else $error("digit address outside the digits in use");
	a_ovf_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ovf_q) |-> out_last_q)
		else $error("overflow flagged on a write that is not the last");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (state_q == ST_SIGN)) |=> (state_q == ST_IDLE))
		else $error("sequencer kept going after the sign");
`endif

endmodule

// File: rtl/signed_decimal_display_writer_top.sv
// signed_decimal_display_writer_top: digit count register, front queue and write sequencer
// depends on sddw_pkg, sddw_if, sddw_front and sddw_back
//
//  channel  | direction | payload                                   | transfer
//  in_ch    | sink      | value (32b signed)                        | valid && ready
//  out_ch   | source    | digit_address, digit_code, last, overflow | valid && ready
//  cfg      | write     | cfg_wdata (4b digit_count)                | cfg_we
//
// a number on a display of c digits takes a load step, c blank writes and then its
// digit and sign writes, capped at c; the sequencer issues one write per cycle while
// the receiver does not stall, and the divide by ten keeps pace.
// the two-entry front queue lets input transfers go on while writes stall, until full.
// arst_n clears control state and sets digit_count to 8.

module signed_decimal_display_writer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	sddw_in_if.sink                      in_ch,
	sddw_out_if.source                   out_ch,
	input  logic                         cfg_we,
	input  logic [sddw_pkg::NIB_W-1:0]   cfg_wdata
);

	logic [sddw_pkg::NIB_W-1:0] digit_count_q;
	logic                       q_valid;
	logic                       q_pop;
	sddw_pkg::queue_entry_t     q_entry;

	// digit count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			digit_count_q <= sddw_pkg::COUNT_RESET;
		else if (cfg_we)
			digit_count_q <= cfg_wdata;
	end

	sddw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	sddw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.count   (sddw_pkg::eff_count(digit_count_q)),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// File: tb/tb_signed_decimal_display_writer_top.sv
// tb_signed_decimal_display_writer_top: self-checking bench for the signed decimal display writer
// depends on sddw_pkg, sddw_in_if, sddw_out_if and signed_decimal_display_writer_top
// numbers are driven on in_ch; every digit write on out_ch is checked against a local prediction

`timescale 1ns / 100ps

module tb_signed_decimal_display_writer_top;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_WAIT  = 24;

	// one expected digit register write
	typedef struct packed {
		logic [sddw_pkg::NIB_W-1:0] digit_address;
		logic [sddw_pkg::NIB_W-1:0] digit_code;
		logic                       last;
		logic                       overflow;
	} digit_write_t;

	// expected digit writes for each accepted number, checked in order
	class display_scoreboard;
		digit_write_t               pending_writes[$];
		logic [sddw_pkg::NIB_W-1:0] digit_count;
		int unsigned                writes_checked;
		int unsigned                error_count;

		function new();
			digit_count    = sddw_pkg::COUNT_RESET;
			writes_checked = 0;
			error_count    = 0;
		endfunction

		function void set_digit_count(logic [sddw_pkg::NIB_W-1:0] count);
			digit_count = count;
		endfunction

		// blanks from the top digit down, then digits lsd first, then the sign
		function void add_number(logic signed [sddw_pkg::VALUE_W-1:0] number);
			int                           used;
			int                           pos;
			logic                         neg;
			logic                         spilled;
			logic [sddw_pkg::VALUE_W-1:0] mag;
			digit_write_t                 w;
			used = int'(digit_count);
			if (used > int'(sddw_pkg::MAX_DIGITS))
				used = int'(sddw_pkg::MAX_DIGITS);
			if (used == 0)
				used = 1;
			neg     = number[sddw_pkg::VALUE_W-1];
			mag     = neg ? (sddw_pkg::VALUE_W'(0) - sddw_pkg::VALUE_W'(number))
				: sddw_pkg::VALUE_W'(number);
			spilled = 1'b0;
			w       = '0;
			for (pos = used; pos >= 1; pos--) begin
				w.digit_address = sddw_pkg::NIB_W'(pos);
				w.digit_code    = sddw_pkg::CODE_BLANK;
				pending_writes.push_back(w);
			end
			pos = 0;
			do begin
				pos++;
				if (pos <= used) begin
					w.digit_address = sddw_pkg::NIB_W'(pos);
					w.digit_code    = sddw_pkg::NIB_W'(mag % 10);
					pending_writes.push_back(w);
				end else begin
					spilled = 1'b1;
				end
				mag = mag / 10;
			end while (mag != 0);
			if (neg) begin
				pos++;
				if (pos <= used) begin
					w.digit_address = sddw_pkg::NIB_W'(pos);
					w.digit_code    = sddw_pkg::CODE_MINUS;
					pending_writes.push_back(w);
				end else begin
					spilled = 1'b1;
				end
			end
			pending_writes[pending_writes.size()-1].last     = 1'b1;
			pending_writes[pending_writes.size()-1].overflow = spilled;
		endfunction

		function void check_write(digit_write_t got);
			digit_write_t exp;
			if (pending_writes.size() == 0) begin
				$error("digit write with none expected: address %0d code %0d",
					got.digit_address, got.digit_code);
				error_count++;
				return;
			end
			exp = pending_writes.pop_front();
			writes_checked++;
			if (got.digit_address !== exp.digit_address) begin
				$error("digit_address: expected %0d, got %0d", exp.digit_address, got.digit_address);
				error_count++;
			end
			if (got.digit_code !== exp.digit_code) begin
				$error("digit_code: expected %0d, got %0d", exp.digit_code, got.digit_code);
				error_count++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %0d, got %0d", exp.last, got.last);
				error_count++;
			end
			if (got.overflow !== exp.overflow) begin
				$error("overflow: expected %0d, got %0d", exp.overflow, got.overflow);
				error_count++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [sddw_pkg::NIB_W-1:0] cfg_wdata;
	logic                       idle_on;
	int unsigned                numbers_sent = 0;
	int unsigned                settings_used = 0;
	int unsigned                cycle_count = 0;
	int unsigned                stall_left = 0;

	display_scoreboard sb;

	sddw_in_if  in_ch ();
	sddw_out_if out_ch ();

	signed_decimal_display_writer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 4 ns clock
	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver stalls in random bursts while idle_on is set
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready = 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left   = $urandom_range(0, 7);
			out_ch.ready = 1'b0;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	// check every digit write transfer
	always @(posedge clk) begin
		digit_write_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.digit_address = out_ch.digit_address;
			got.digit_code    = out_ch.digit_code;
			got.last          = out_ch.last;
			got.overflow      = out_ch.overflow;
			sb.check_write(got);
		end
	end

	// present one number, with an optional gap first, until its transfer
	task automatic send_number(input logic signed [sddw_pkg::VALUE_W-1:0] number);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.value = number;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.add_number(number);
		numbers_sent++;
		@(negedge clk);
	endtask

	// wait for all writes to arrive and the sequencer to settle
	task automatic wait_for_drain();
		in_ch.valid = 1'b0;
		while (sb.pending_writes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// digit count is only changed while the block is idle
	task automatic write_digit_count(input logic [sddw_pkg::NIB_W-1:0] count);
		wait_for_drain();
		cfg_we    = 1'b1;
		cfg_wdata = count;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_digit_count(count);
		settings_used++;
	endtask

	initial begin
		logic signed [sddw_pkg::VALUE_W-1:0] corner_values [24];
		logic [sddw_pkg::NIB_W-1:0]          count_plan [12];
		longint unsigned                     span;
		logic [sddw_pkg::VALUE_W-1:0]        mag;
		int unsigned                         sel;

		corner_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
			32'sd99, 32'sd100, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
			32'sd12345678, -32'sd1234567, -32'sd12345678, 32'sd99999999,
			32'sd100000000, -32'sd99999999, 32'sd1000000000, 32'sd1073741824,
			32'sd7, -32'sd5, 32'sd80808080, 32'sd1999999999};
		// extremes, out-of-range codes and every bit of the register both ways
		count_plan = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd12, 4'd2, 4'd7, 4'd4,
			4'd6, 4'd8};

		sb          = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		idle_on     = 1'b1;
		in_ch.valid = 1'b0;
		in_ch.value = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner numbers at the reset digit count
		foreach (corner_values[i])
			send_number(corner_values[i]);

		// random numbers under each digit count, last phase without idling
		foreach (count_plan[p]) begin
			if (p == $size(count_plan) - 1)
				idle_on = 1'b0;
			write_digit_count(count_plan[p]);
			repeat (34) begin
				sel = $urandom_range(0, 9);
				if (sel < 2) begin
					mag = $urandom();
					send_number(mag);
				end else if (sel == 2) begin
					send_number(corner_values[$urandom_range(0, 23)]);
				end else begin
					// mostly short numbers so that every digit count is exercised
					span = 1;
					repeat ($urandom_range(1, 10)) span = span * 10;
					mag = sddw_pkg::VALUE_W'({32'd0, $urandom()} % span);
					send_number($urandom_range(0, 1) ? -mag : mag);
				end
			end
		end

		wait_for_drain();
		$display("%0d numbers sent under %0d digit count settings plus reset, %0d digit writes checked",
			numbers_sent, settings_used, sb.writes_checked);
		if (sb.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: signed_decimal_display_writer_top.f
rtl/sddw_pkg.sv
rtl/sddw_if.sv
rtl/sddw_front.sv
rtl/sddw_back.sv
rtl/signed_decimal_display_writer_top.sv
tb/tb_signed_decimal_display_writer_top.sv
